// ===== rtl/chained_xor_packet_cipher_top_defines.svh =====
// Assertion macros for the chained XOR packet cipher
`ifndef CHAINED_XOR_PACKET_CIPHER_TOP_DEFINES_SVH
`define CHAINED_XOR_PACKET_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CXPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CXPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CXPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CXPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/cxpc_pkg.sv =====
// Package: types and constants of the chained XOR packet cipher
`timescale 1ns / 1ps

package cxpc_pkg;

    localparam int BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [0:0] {
        CFG_DIRECTION = 1'b0,
        CFG_FIXED_KEY = 1'b1
    } cfg_index_t;

    localparam logic DIR_DECRYPT = 1'b0;
    localparam logic DIR_ENCRYPT = 1'b1;

    typedef struct packed {
        byte_t data;
        byte_t rkey;
        logic  first;
        logic  last;
    } in_word_t;

    typedef struct packed {
        byte_t data;
        logic  eop;
        logic  ok;
    } out_word_t;

endpackage

// ===== rtl/chained_xor_packet_cipher_top.sv =====
// Top level: byte-serial two-stage chained XOR cipher with checksum check
//
// Input channel (in_valid/in_ready) carries one word per byte of a packet
// section: data_byte, random_key, first (checksum byte), last (final byte).
// Output channel (out_valid/out_ready) returns one word per input word:
// out_byte, end_of_packet (copy of last) and checksum_ok (on the last byte,
// payload sum mod 256 equals the plain checksum byte; 0 otherwise).
// Config port: cfg_we/cfg_index/cfg_data writes direction (index 0,
// 0 decrypt, 1 encrypt) and fixed_key (index 1); write only while idle.
// Path: an accepted word goes to the input register, then to the result
// register, which loads when empty or being taken; out_valid rises as it
// loads. Throughput: one word per cycle unless the receiver stalls; the
// cipher chain's 8-bit adds and two XORs sit in the single stage between the registers.
// Reset clears the chain state, the config registers and both valid flags.
// When the receiver stalls the result register holds, the input register
// fills, and in_ready drops until the result is taken; nothing is lost.
`timescale 1ns / 1ps
`include "chained_xor_packet_cipher_top_defines.svh"

module chained_xor_packet_cipher_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cxpc_pkg::byte_t      data_byte,
    input  cxpc_pkg::byte_t      random_key,
    input  logic                 first,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cxpc_pkg::byte_t      out_byte,
    output logic                 end_of_packet,
    output logic                 checksum_ok,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  cxpc_pkg::byte_t      cfg_data
);

    logic                 direction_reg;
    cxpc_pkg::byte_t      fixed_key_reg;

    cxpc_pkg::in_word_t   s1_reg;
    logic                 s1_valid_reg;
    cxpc_pkg::out_word_t  out_reg;
    logic                 out_valid_reg;

    cxpc_pkg::byte_t      prev_inner_reg, prev_inner_next;
    cxpc_pkg::byte_t      prev_outer_reg, prev_outer_next;
    cxpc_pkg::byte_t      byte_index_reg, byte_index_next;
    cxpc_pkg::byte_t      payload_sum_reg, payload_sum_next;
    cxpc_pkg::byte_t      expected_sum_reg, expected_sum_next;

    cxpc_pkg::byte_t      base_inner, base_outer, base_index, base_sum;
    cxpc_pkg::byte_t      pos, inner_key, outer_key, mid, plain, res;
    cxpc_pkg::out_word_t  out_next;

    logic in_fire, s1_adv;
    cxpc_pkg::cfg_index_t cfg_sel;

    assign cfg_sel  = cxpc_pkg::cfg_index_t'(cfg_index);
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= cxpc_pkg::DIR_DECRYPT;
            fixed_key_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                cxpc_pkg::CFG_DIRECTION: direction_reg <= cfg_data[0];
                cxpc_pkg::CFG_FIXED_KEY: fixed_key_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // cipher step on the word held in the input register
    always_comb
    begin
        base_inner = s1_reg.first ? '0 : prev_inner_reg;
        base_outer = s1_reg.first ? '0 : prev_outer_reg;
        base_index = s1_reg.first ? '0 : byte_index_reg;
        base_sum   = s1_reg.first ? '0 : payload_sum_reg;
        pos        = base_index + 8'd1;
        inner_key  = base_inner + s1_reg.rkey + pos;
        outer_key  = base_outer + fixed_key_reg + pos;

        if (direction_reg == cxpc_pkg::DIR_ENCRYPT)
        begin
            plain           = s1_reg.data;
            mid             = s1_reg.data ^ inner_key;
            res             = mid ^ outer_key;
            prev_outer_next = res;
        end
        else
        begin
            mid             = s1_reg.data ^ outer_key;
            plain           = mid ^ inner_key;
            res             = plain;
            prev_outer_next = s1_reg.data;
        end

        prev_inner_next   = mid;
        byte_index_next   = pos;
        payload_sum_next  = s1_reg.first ? base_sum : base_sum + plain;
        expected_sum_next = s1_reg.first ? plain : expected_sum_reg;

        out_next.data = res;
        out_next.eop  = s1_reg.last;
        out_next.ok   = s1_reg.last && (payload_sum_next == expected_sum_next);
    end

    // chain state, updated as a word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_inner_reg   <= '0;
            prev_outer_reg   <= '0;
            byte_index_reg   <= '0;
            payload_sum_reg  <= '0;
            expected_sum_reg <= '0;
        end
        else if (s1_adv)
        begin
            prev_inner_reg   <= prev_inner_next;
            prev_outer_reg   <= prev_outer_next;
            byte_index_reg   <= byte_index_next;
            payload_sum_reg  <= payload_sum_next;
            expected_sum_reg <= expected_sum_next;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg.data  <= data_byte;
            s1_reg.rkey  <= random_key;
            s1_reg.first <= first;
            s1_reg.last  <= last;
        end
        if (s1_adv)
            out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_reg.data;
    assign end_of_packet = out_reg.eop;
    assign checksum_ok   = out_reg.ok;

    `CXPC_ASSERT_IMPL(a_ok_only_on_eop, clk, rst_n, out_valid_reg && out_reg.ok, out_reg.eop, "checksum_ok without end_of_packet")
    `CXPC_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !s1_valid_reg, in_ready, "in_ready low with empty input register")
    `CXPC_ASSERT_NEXT(a_first_restarts_index, clk, rst_n, s1_adv && s1_reg.first, byte_index_reg == 8'd1, "byte index not restarted on first byte")

endmodule

// ===== tb/chained_xor_packet_cipher_top_tb.sv =====
// Testbench for chained_xor_packet_cipher_top: random traffic against a predictor
`timescale 1ns / 1ps

module chained_xor_packet_cipher_top_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 110;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    cxpc_pkg::byte_t data_byte = '0;
    cxpc_pkg::byte_t random_key = '0;
    logic  first = 1'b0;
    logic  last = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    cxpc_pkg::byte_t out_byte;
    logic  end_of_packet;
    logic  checksum_ok;
    logic  cfg_we = 1'b0;
    logic  cfg_index = cxpc_pkg::CFG_DIRECTION;
    cxpc_pkg::byte_t cfg_data = '0;

    // predictor copy of config and chain state
    logic  cfg_dir = cxpc_pkg::DIR_DECRYPT;
    cxpc_pkg::byte_t cfg_fkey = '0;
    cxpc_pkg::byte_t chain_inner = '0;
    cxpc_pkg::byte_t chain_outer = '0;
    cxpc_pkg::byte_t chain_pos = '0;
    cxpc_pkg::byte_t payload_total = '0;
    cxpc_pkg::byte_t checksum_ref = '0;

    cxpc_pkg::in_word_t  pending_words[$];
    cxpc_pkg::out_word_t expected_words[$];
    cxpc_pkg::in_word_t  cur_word;
    int        send_gap = 0;
    int        recv_hold = 0;
    int        staged_words = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        stall_cycles = 0;
    bit        idle_on = 1'b1;

    chained_xor_packet_cipher_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .random_key    (random_key),
        .first         (first),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .end_of_packet (end_of_packet),
        .checksum_ok   (checksum_ok),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic cxpc_pkg::out_word_t predict_cipher_word(cxpc_pkg::in_word_t w);
        cxpc_pkg::byte_t     pos;
        cxpc_pkg::byte_t     p;
        cxpc_pkg::byte_t     plain;
        cxpc_pkg::out_word_t r;
        if (w.first)
        begin
            chain_inner = '0;
            chain_outer = '0;
            chain_pos = '0;
            payload_total = '0;
        end
        pos = chain_pos + 8'd1;
        if (cfg_dir == cxpc_pkg::DIR_ENCRYPT)
        begin
            plain = w.data;
            p = w.data ^ cxpc_pkg::byte_t'(chain_inner + w.rkey + pos);
            r.data = p ^ cxpc_pkg::byte_t'(chain_outer + cfg_fkey + pos);
            chain_outer = r.data;
        end
        else
        begin
            p = w.data ^ cxpc_pkg::byte_t'(chain_outer + cfg_fkey + pos);
            plain = p ^ cxpc_pkg::byte_t'(chain_inner + w.rkey + pos);
            r.data = plain;
            chain_outer = w.data;
        end
        chain_inner = p;
        chain_pos = pos;
        if (w.first)
            checksum_ref = plain;
        else
            payload_total = payload_total + plain;
        r.eop = w.last;
        r.ok = w.last && (payload_total == checksum_ref);
        return r;
    endfunction

    task automatic queue_word(cxpc_pkg::byte_t d, cxpc_pkg::byte_t rk, logic f, logic l);
        cxpc_pkg::in_word_t w;
        w.data = d;
        w.rkey = rk;
        w.first = f;
        w.last = l;
        pending_words.push_back(w);
        staged_words++;
    endtask

    // builds a section from plain bytes; in decrypt mode it is encrypted first
    task automatic queue_packet(int payload_len, bit sum_good, bit closed);
        cxpc_pkg::byte_t plain[$];
        cxpc_pkg::byte_t rkey;
        cxpc_pkg::byte_t total;
        cxpc_pkg::byte_t b;
        cxpc_pkg::byte_t inner;
        cxpc_pkg::byte_t outer;
        cxpc_pkg::byte_t pos;
        cxpc_pkg::byte_t p;
        cxpc_pkg::byte_t d;
        rkey = cxpc_pkg::byte_t'($urandom);
        total = '0;
        plain.push_back('0);
        for (int k = 0; k < payload_len; k++)
        begin
            b = cxpc_pkg::byte_t'($urandom);
            plain.push_back(b);
            total = total + b;
        end
        plain[0] = sum_good ? total : total ^ cxpc_pkg::byte_t'($urandom_range(1, 255));
        inner = '0;
        outer = '0;
        for (int k = 0; k < plain.size(); k++)
        begin
            pos = cxpc_pkg::byte_t'(k + 1);
            d = plain[k];
            if (cfg_dir == cxpc_pkg::DIR_DECRYPT)
            begin
                p = plain[k] ^ cxpc_pkg::byte_t'(inner + rkey + pos);
                outer = p ^ cxpc_pkg::byte_t'(outer + cfg_fkey + pos);
                inner = p;
                d = outer;
            end
            queue_word(d, rkey, k == 0, closed && (k == plain.size() - 1));
        end
    endtask

    task automatic cfg_write(cxpc_pkg::cfg_index_t idx, cxpc_pkg::byte_t val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == cxpc_pkg::CFG_DIRECTION)
            cfg_dir = val[0];
        else
            cfg_fkey = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_words.push_back(predict_cipher_word(cur_word));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    data_byte <= cur_word.data;
                    random_key <= cur_word.rkey;
                    first <= cur_word.first;
                    last <= cur_word.last;
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word at %0t: byte %02h eop %0b ok %0b",
                                 $realtime, out_byte, end_of_packet, checksum_ok);
                end
                else
                begin
                    automatic cxpc_pkg::out_word_t exp_w = expected_words.pop_front();
                    if (out_byte !== exp_w.data || end_of_packet !== exp_w.eop
                        || checksum_ok !== exp_w.ok)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     $realtime, exp_w.data, exp_w.eop, exp_w.ok,
                                     out_byte, end_of_packet, checksum_ok);
                    end
                end
                results_seen++;
                // long hold-off so the input side backs up
                if (idle_on && results_seen % 250 == 100)
                    recv_hold = 80;
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                recv_hold = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else if (++stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        cxpc_pkg::byte_t dir_val;
        int    r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // decrypt at reset config: stray words, empty and short sections
        queue_word(8'h00, 8'hFF, 1'b0, 1'b0);
        queue_word(8'hFF, 8'h00, 1'b0, 1'b1);
        queue_word(8'h5A, 8'hA5, 1'b0, 1'b0);
        queue_packet(0, 1'b1, 1'b1);
        queue_packet(3, 1'b1, 1'b1);
        settle();
        cfg_write(cxpc_pkg::CFG_DIRECTION, 8'hFF);
        cfg_write(cxpc_pkg::CFG_FIXED_KEY, 8'hFF);
        @(negedge clk);
        queue_word(8'h00, 8'h00, 1'b1, 1'b1);
        queue_word(8'hFF, 8'hFF, 1'b1, 1'b1);
        queue_packet(4, 1'b1, 1'b1);
        queue_packet(2, 1'b0, 1'b1);
        queue_word(8'h00, 8'hFF, 1'b1, 1'b0);
        queue_word(8'hFF, 8'h00, 1'b0, 1'b0);
        settle();
        // change both registers in the middle of a section
        cfg_write(cxpc_pkg::CFG_FIXED_KEY, 8'h00);
        cfg_write(cxpc_pkg::CFG_DIRECTION, 8'h00);
        @(negedge clk);
        queue_word(8'hFF, 8'hFF, 1'b0, 1'b0);
        queue_word(8'h00, 8'h00, 1'b0, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            dir_val = cxpc_pkg::byte_t'($urandom);
            dir_val[0] = (ph < 2) ? ph[0] : logic'($urandom_range(0, 1));
            cfg_write(cxpc_pkg::CFG_DIRECTION, dir_val);
            cfg_write(cxpc_pkg::CFG_FIXED_KEY,
                      (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : cxpc_pkg::byte_t'($urandom));
            @(negedge clk);
            idle_on = (ph < 6);
            staged_words = 0;
            if (ph == 2)
                queue_packet(270, 1'b1, 1'b1);
            while (staged_words < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    queue_packet($urandom_range(0, 12), 1'b1, 1'b1);
                else if (r < 82)
                    queue_packet($urandom_range(0, 12), 1'b0, 1'b1);
                else if (r < 88)
                    queue_packet($urandom_range(1, 6), 1'b1, 1'b0);
                else
                    queue_word(cxpc_pkg::byte_t'($urandom), cxpc_pkg::byte_t'($urandom),
                               logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
            end
        end

        settle();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
